>>> src/scfe_pkg.sv
package scfe_pkg;

    // frame buffer geometry
    localparam int FRAME_BYTES = 10;
    localparam int IDX_W       = $clog2(FRAME_BYTES + 1);
    localparam int SLOT_W      = $clog2(FRAME_BYTES);

    // outgoing frame
    localparam int FRAME_LEN = 8;
    localparam int BEAT_W    = $clog2(FRAME_LEN);

    // frame bytes
    localparam logic [7:0] START_MARK = 8'h7E;
    localparam logic [7:0] VERSION    = 8'hFF;
    localparam logic [7:0] LEN_BYTE   = 8'h06;
    localparam logic [7:0] FEEDBACK   = 8'h01;
    localparam logic [7:0] END_MARK   = 8'hEF;

    // frame byte positions of the decoded fields
    localparam int POS_CODE = 3;
    localparam int POS_HIGH = 5;
    localparam int POS_LOW  = 6;

    // command codes
    localparam logic [7:0] CMD_SET_VOLUME = 8'h06;
    localparam logic [7:0] VOLUME_MAX     = 8'd30;

    // response codes
    localparam logic [7:0] RSP_CARD_IN      = 8'h3A;
    localparam logic [7:0] RSP_CARD_OUT     = 8'h3D;
    localparam logic [7:0] RSP_ERROR        = 8'h40;
    localparam logic [7:0] RSP_ACK          = 8'h41;
    localparam logic [7:0] RSP_STATUS       = 8'h42;
    localparam logic [7:0] RSP_VOLUME       = 8'h43;
    localparam logic [7:0] RSP_TRACK        = 8'h48;
    localparam logic [7:0] RSP_PLAYING      = 8'h4C;
    localparam logic [7:0] RSP_FOLDER_FILES = 8'h4E;
    localparam logic [7:0] RSP_FOLDER_COUNT = 8'h4F;

    typedef enum logic [1:0] {
        OUT_TAKEN   = 2'd0,
        OUT_KNOWN   = 2'd1,
        OUT_UNKNOWN = 2'd2
    } rx_outcome_t;

    // completed receive frame
    typedef struct packed {
        logic        done;
        logic [7:0]  code;
        logic [15:0] data;
    } rx_evt_t;

    // player-visible state
    typedef struct packed {
        logic        card;
        logic [15:0] track;
        logic [7:0]  status;
        logic [7:0]  volume;
        logic [7:0]  resp_code;
        logic [15:0] resp_data;
        logic [7:0]  sent_code;
        logic [15:0] sent_data;
    } player_state_t;

    // volume set requests are limited to the top volume step
    function automatic logic [7:0] clamp_low(input logic [7:0] code, input logic [7:0] lo);
        logic [7:0] res;
        res = lo;
        if (code == CMD_SET_VOLUME && lo > VOLUME_MAX)
        begin
            res = VOLUME_MAX;
        end
        return res;
    endfunction

endpackage

>>> src/serial_command_frame_engine_core.sv
// a request waits in the input register and its results come from the output register
// throughput: one received byte per cycle while out_stall is low; a send request holds
// the input register until its frame is out, one frame byte per unstalled cycle
// reset: asynchronous active-low rst_n clears the frame buffer, frame index,
// player state and both handshake registers
module serial_command_frame_engine_core
    import scfe_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        command,
    input  logic [7:0]  rx_byte,
    input  logic [7:0]  cmd_code,
    input  logic [7:0]  param_high,
    input  logic [7:0]  param_low,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        is_tx_byte,
    output logic [7:0]  tx_byte,
    output logic        last_of_run,
    output logic [1:0]  rx_outcome,
    output logic        card_inserted,
    output logic [15:0] track_value,
    output logic [7:0]  player_status,
    output logic [7:0]  volume_level,
    output logic [7:0]  response_code,
    output logic [15:0] response_data,
    output logic [7:0]  sent_code,
    output logic [15:0] sent_data
);

    logic          in_full_reg;
    logic          cmd_reg;
    logic [7:0]    rxb_reg;
    logic [7:0]    code_reg;
    logic [7:0]    hi_reg;
    logic [7:0]    lo_reg;

    logic          out_valid_reg;
    logic          is_tx_reg;
    logic [7:0]    tx_byte_reg;
    logic          last_reg;
    rx_outcome_t   outcome_reg;
    player_state_t out_st_reg;

    logic          load;
    logic          pop;
    logic          accept;
    logic          step_rx;
    logic          step_tx;
    logic [7:0]    lo_clamped;
    logic [7:0]    seq_byte;
    logic          seq_last;
    rx_evt_t       evt;
    player_state_t st_next;
    rx_outcome_t   outcome;

    // handshake
    assign load       = in_full_reg && (!out_valid_reg || !out_stall);
    assign pop        = load && (!cmd_reg || seq_last);
    assign in_stall   = in_full_reg && !pop;
    assign accept     = in_valid && !in_stall;
    assign step_rx    = load && !cmd_reg;
    assign step_tx    = load && cmd_reg;
    assign lo_clamped = clamp_low(code_reg, lo_reg);

    scfe_rx u_rx (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (step_rx),
        .rx_byte (rxb_reg),
        .evt     (evt)
    );

    scfe_tx u_tx (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (step_tx),
        .code    (code_reg),
        .hi      (hi_reg),
        .lo      (lo_clamped),
        .tx_byte (seq_byte),
        .last    (seq_last)
    );

    scfe_state u_state (
        .clk     (clk),
        .rst_n   (rst_n),
        .step_rx (step_rx),
        .step_tx (step_tx),
        .evt     (evt),
        .tx_code (code_reg),
        .tx_data ({hi_reg, lo_clamped}),
        .st_next (st_next),
        .outcome (outcome)
    );

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_full_reg <= 1'b0;
        end
        else if (accept)
        begin
            in_full_reg <= 1'b1;
        end
        else if (pop)
        begin
            in_full_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg  <= command;
            rxb_reg  <= rx_byte;
            code_reg <= cmd_code;
            hi_reg   <= param_high;
            lo_reg   <= param_low;
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            is_tx_reg   <= cmd_reg;
            tx_byte_reg <= cmd_reg ? seq_byte : 8'd0;
            last_reg    <= !cmd_reg || seq_last;
            outcome_reg <= cmd_reg ? OUT_TAKEN : outcome;
            out_st_reg  <= st_next;
        end
    end

    // result ports
    assign out_valid     = out_valid_reg;
    assign is_tx_byte    = is_tx_reg;
    assign tx_byte       = tx_byte_reg;
    assign last_of_run   = last_reg;
    assign rx_outcome    = outcome_reg;
    assign card_inserted = out_st_reg.card;
    assign track_value   = out_st_reg.track;
    assign player_status = out_st_reg.status;
    assign volume_level  = out_st_reg.volume;
    assign response_code = out_st_reg.resp_code;
    assign response_data = out_st_reg.resp_data;
    assign sent_code     = out_st_reg.sent_code;
    assign sent_data     = out_st_reg.sent_data;

`ifndef SYNTHESIS
    a_frame_pending: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && is_tx_reg && !last_reg |-> in_full_reg && cmd_reg)
        else $error("send request released before its frame was done");

    a_rx_single: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !is_tx_reg |-> last_reg)
        else $error("receive result not marked last");

    a_frame_end: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && is_tx_reg && last_reg |-> tx_byte_reg == END_MARK)
        else $error("last frame byte is not the end mark");

    a_send_clears: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && is_tx_reg |-> out_st_reg.resp_code == 8'd0
            && out_st_reg.resp_data == 16'd0)
        else $error("response not cleared by a send");
`endif

endmodule

>>> src/scfe_rx.sv
module scfe_rx
    import scfe_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       step,
    input  logic [7:0] rx_byte,
    output rx_evt_t    evt
);

    logic [IDX_W-1:0] idx_reg;
    logic [IDX_W-1:0] idx_next;
    logic [IDX_W-1:0] idx_wr;
    logic [7:0]       store_reg  [FRAME_BYTES];
    logic [7:0]       store_next [FRAME_BYTES];

    // wrap, store, track start and end marks
    always_comb
    begin
        idx_wr = (idx_reg >= IDX_W'(FRAME_BYTES)) ? '0 : idx_reg;
        store_next = store_reg;
        store_next[idx_wr[SLOT_W-1:0]] = rx_byte;
        evt.done = 1'b0;
        if (idx_wr == '0)
        begin
            idx_next = (rx_byte == START_MARK) ? IDX_W'(1) : '0;
        end
        else if (rx_byte == END_MARK)
        begin
            idx_next = '0;
            evt.done = 1'b1;
        end
        else
        begin
            idx_next = idx_wr + IDX_W'(1);
        end
        evt.code = store_next[POS_CODE];
        evt.data = {store_next[POS_HIGH], store_next[POS_LOW]};
    end

    // frame buffer and index
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg <= '0;
            for (int i = 0; i < FRAME_BYTES; i++)
            begin
                store_reg[i] <= '0;
            end
        end
        else if (step)
        begin
            idx_reg   <= idx_next;
            store_reg <= store_next;
        end
    end

`ifndef SYNTHESIS
    a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
        idx_reg <= IDX_W'(FRAME_BYTES))
        else $error("frame index past buffer size");
`endif

endmodule

>>> src/scfe_state.sv
module scfe_state
    import scfe_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          step_rx,
    input  logic          step_tx,
    input  rx_evt_t       evt,
    input  logic [7:0]    tx_code,
    input  logic [15:0]   tx_data,
    output player_state_t st_next,
    output rx_outcome_t   outcome
);

    player_state_t st_reg;

    // apply a send request or a decoded response
    always_comb
    begin
        st_next = st_reg;
        outcome = OUT_TAKEN;
        if (step_tx)
        begin
            st_next.sent_code = tx_code;
            st_next.sent_data = tx_data;
            st_next.resp_code = '0;
            st_next.resp_data = '0;
        end
        else if (step_rx && evt.done)
        begin
            st_next.resp_code = evt.code;
            st_next.resp_data = evt.data;
            outcome = OUT_KNOWN;
            case (evt.code)
                RSP_CARD_IN:  st_next.card = 1'b1;
                RSP_CARD_OUT: st_next.track = '0;
                RSP_STATUS:
                begin
                    st_next.status = evt.data[7:0];
                    if (evt.data[7:0] == 8'd0)
                    begin
                        st_next.track = '0;
                    end
                end
                RSP_VOLUME:   st_next.volume = evt.data[7:0];
                RSP_TRACK:    st_next.track = evt.data;
                RSP_ERROR, RSP_ACK, RSP_PLAYING, RSP_FOLDER_FILES, RSP_FOLDER_COUNT:
                begin
                    outcome = OUT_KNOWN;
                end
                default:      outcome = OUT_UNKNOWN;
            endcase
        end
    end

    // player state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= '0;
        end
        else
        begin
            st_reg <= st_next;
        end
    end

endmodule

>>> src/scfe_tx.sv
module scfe_tx
    import scfe_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       advance,
    input  logic [7:0] code,
    input  logic [7:0] hi,
    input  logic [7:0] lo,
    output logic [7:0] tx_byte,
    output logic       last
);

    logic [BEAT_W-1:0] beat_reg;

    // frame byte for the current beat
    always_comb
    begin
        case (beat_reg)
            BEAT_W'(0): tx_byte = START_MARK;
            BEAT_W'(1): tx_byte = VERSION;
            BEAT_W'(2): tx_byte = LEN_BYTE;
            BEAT_W'(3): tx_byte = code;
            BEAT_W'(4): tx_byte = FEEDBACK;
            BEAT_W'(5): tx_byte = hi;
            BEAT_W'(6): tx_byte = lo;
            default:    tx_byte = END_MARK;
        endcase
        last = (beat_reg == BEAT_W'(FRAME_LEN - 1));
    end

    // beat counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            beat_reg <= '0;
        end
        else if (advance)
        begin
            beat_reg <= last ? '0 : beat_reg + BEAT_W'(1);
        end
    end

endmodule

>>> tb/sv/serial_command_frame_engine_core_test.sv
module serial_command_frame_engine_core_test;
    import scfe_pkg::*;

    localparam int STUCK_LIMIT = 1000;
    localparam int TAIL_CYCLES = 16;
    localparam int BATCH_ITEMS = 120;

    localparam logic [7:0] RESPONSE_CODES [10] = '{
        RSP_CARD_IN, RSP_CARD_OUT, RSP_ERROR, RSP_ACK, RSP_STATUS,
        RSP_VOLUME, RSP_TRACK, RSP_PLAYING, RSP_FOLDER_FILES, RSP_FOLDER_COUNT
    };

    typedef struct {
        logic       command;
        logic [7:0] rx_byte;
        logic [7:0] cmd_code;
        logic [7:0] param_high;
        logic [7:0] param_low;
    } request_t;

    typedef struct {
        logic          is_tx;
        logic [7:0]    tx;
        logic          last;
        rx_outcome_t   outcome;
        player_state_t st;
    } frame_beat_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic        command = 1'b0;
    logic [7:0]  rx_byte = '0;
    logic [7:0]  cmd_code = '0;
    logic [7:0]  param_high = '0;
    logic [7:0]  param_low = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic        is_tx_byte;
    logic [7:0]  tx_byte;
    logic        last_of_run;
    logic [1:0]  rx_outcome;
    logic        card_inserted;
    logic [15:0] track_value;
    logic [7:0]  player_status;
    logic [7:0]  volume_level;
    logic [7:0]  response_code;
    logic [15:0] response_data;
    logic [7:0]  sent_code;
    logic [15:0] sent_data;

    // stimulus and expected beats
    request_t    request_q [$];
    frame_beat_t due_beats [$];

    // shadow copy of the block state
    player_state_t    shadow = '0;
    logic [IDX_W-1:0] shadow_idx = '0;
    logic [7:0]       shadow_buf [FRAME_BYTES] = '{default: 8'h00};

    int unsigned send_idle_pct = 0;
    int unsigned recv_idle_pct = 0;
    int requests_shown = 0;
    int requests_taken = 0;
    int sends_done = 0;
    int bytes_taken = 0;
    int frames_closed = 0;
    int frames_unknown = 0;
    int results_checked = 0;
    int mismatches = 0;
    int stuck_cycles = 0;

    serial_command_frame_engine_core dut (.*);

    always #1 clk = ~clk;

    task automatic report_mismatch(input string what, input logic [15:0] got,
                                   input logic [15:0] want);
        mismatches++;
        $display("%0t: %s: got %h, expected %h", $time, what, got, want);
    endtask

    task automatic check_field(input string what, input logic [15:0] got,
                               input logic [15:0] want);
        if (got !== want)
        begin
            report_mismatch(what, got, want);
        end
    endtask

    // decode bytes 3, 5 and 6 of the frame buffer into the player state
    function automatic rx_outcome_t decode_response();
        rx_outcome_t res;
        res = OUT_KNOWN;
        shadow.resp_code = shadow_buf[POS_CODE];
        shadow.resp_data = {shadow_buf[POS_HIGH], shadow_buf[POS_LOW]};
        case (shadow.resp_code)
            RSP_CARD_IN:
            begin
                shadow.card = 1'b1;
            end
            RSP_CARD_OUT:
            begin
                shadow.track = '0;
            end
            RSP_STATUS:
            begin
                shadow.status = shadow.resp_data[7:0];
                if (shadow.status == 8'h00)
                begin
                    shadow.track = '0;
                end
            end
            RSP_VOLUME:
            begin
                shadow.volume = shadow.resp_data[7:0];
            end
            RSP_TRACK:
            begin
                shadow.track = shadow.resp_data;
            end
            RSP_ERROR, RSP_ACK, RSP_PLAYING, RSP_FOLDER_FILES, RSP_FOLDER_COUNT:
            begin
                res = OUT_KNOWN;
            end
            default:
            begin
                res = OUT_UNKNOWN;
            end
        endcase
        return res;
    endfunction

    // advance the shadow state by one request and queue the beats it causes
    task automatic predict_player_step(input request_t r);
        frame_beat_t beat;
        logic [7:0]  lo_sent;
        logic [7:0]  frame [FRAME_LEN];
        rx_outcome_t outcome;
        int          k;
        if (r.command)
        begin
            lo_sent = r.param_low;
            if (r.cmd_code == CMD_SET_VOLUME && r.param_low > VOLUME_MAX)
            begin
                lo_sent = VOLUME_MAX;
            end
            frame = '{START_MARK, VERSION, LEN_BYTE, r.cmd_code, FEEDBACK,
                      r.param_high, lo_sent, END_MARK};
            shadow.sent_code = r.cmd_code;
            shadow.sent_data = {r.param_high, lo_sent};
            shadow.resp_code = '0;
            shadow.resp_data = '0;
            sends_done++;
            for (k = 0; k < FRAME_LEN; k++)
            begin
                beat.is_tx   = 1'b1;
                beat.tx      = frame[k];
                beat.last    = (k == FRAME_LEN - 1);
                beat.outcome = OUT_TAKEN;
                beat.st      = shadow;
                due_beats.push_back(beat);
            end
        end
        else
        begin
            outcome = OUT_TAKEN;
            bytes_taken++;
            if (shadow_idx >= FRAME_BYTES)
            begin
                shadow_idx = '0;
            end
            shadow_buf[shadow_idx] = r.rx_byte;
            if (shadow_idx == 0)
            begin
                if (r.rx_byte == START_MARK)
                begin
                    shadow_idx = IDX_W'(1);
                end
            end
            else
            begin
                shadow_idx = shadow_idx + 1'b1;
                if (r.rx_byte == END_MARK)
                begin
                    shadow_idx = '0;
                    outcome = decode_response();
                    frames_closed++;
                    if (outcome == OUT_UNKNOWN)
                    begin
                        frames_unknown++;
                    end
                end
            end
            beat.is_tx   = 1'b0;
            beat.tx      = '0;
            beat.last    = 1'b1;
            beat.outcome = outcome;
            beat.st      = shadow;
            due_beats.push_back(beat);
        end
    endtask

    task automatic push_rx(input logic [7:0] b);
        request_t r;
        r.command    = 1'b0;
        r.rx_byte    = b;
        r.cmd_code   = 8'($urandom_range(0, 255));
        r.param_high = 8'($urandom_range(0, 255));
        r.param_low  = 8'($urandom_range(0, 255));
        request_q.push_back(r);
    endtask

    task automatic push_send(input logic [7:0] code, input logic [7:0] hi,
                             input logic [7:0] lo);
        request_t r;
        r.command    = 1'b1;
        r.rx_byte    = 8'($urandom_range(0, 255));
        r.cmd_code   = code;
        r.param_high = hi;
        r.param_low  = lo;
        request_q.push_back(r);
    endtask

    task automatic push_frame(input logic [7:0] code, input logic [7:0] fb,
                              input logic [7:0] hi, input logic [7:0] lo);
        push_rx(START_MARK);
        push_rx(VERSION);
        push_rx(LEN_BYTE);
        push_rx(code);
        push_rx(fb);
        push_rx(hi);
        push_rx(lo);
        push_rx(END_MARK);
    endtask

    // mostly well-formed response frames, plus sends, overlong and cut frames, noise
    task automatic add_random_requests(input int n);
        int          base;
        int          pick;
        int          extra;
        int          k;
        logic [7:0]  code;
        logic [7:0]  lo;
        logic [7:0]  b;
        base = request_q.size();
        while (request_q.size() - base < n)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 15)
            begin
                code = ($urandom_range(0, 2) == 0) ? CMD_SET_VOLUME : 8'($urandom_range(0, 255));
                lo = ($urandom_range(0, 1) == 0) ? 8'($urandom_range(25, 35))
                                                 : 8'($urandom_range(0, 255));
                push_send(code, 8'($urandom_range(0, 255)), lo);
            end
            else if (pick < 65)
            begin
                code = ($urandom_range(0, 4) == 0) ? 8'($urandom_range(0, 255))
                                                   : RESPONSE_CODES[$urandom_range(0, 9)];
                lo = 8'($urandom_range(0, 255));
                if (code == RSP_STATUS && $urandom_range(0, 1) == 0)
                begin
                    lo = 8'h00;
                end
                push_frame(code, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), lo);
            end
            else if (pick < 85)
            begin
                // overlong frame can wrap the buffer, cut frame decodes stale bytes
                extra = (pick < 75) ? $urandom_range(8, 12) : $urandom_range(0, 4);
                push_rx(START_MARK);
                for (k = 0; k < extra; k++)
                begin
                    b = 8'($urandom_range(0, 255));
                    if (b == END_MARK)
                    begin
                        b = 8'h00;
                    end
                    push_rx(b);
                end
                push_rx(END_MARK);
            end
            else
            begin
                case ($urandom_range(0, 3))
                    0: push_rx(START_MARK);
                    1: push_rx(END_MARK);
                    default: push_rx(8'($urandom_range(0, 255)));
                endcase
            end
        end
    endtask

    // request driver
    always @(negedge clk)
    begin : driver
        request_t r;
        out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
        if (rst_n && (!in_valid || requests_taken == requests_shown))
        begin
            if (request_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct)
            begin
                r = request_q.pop_front();
                command    <= r.command;
                rx_byte    <= r.rx_byte;
                cmd_code   <= r.cmd_code;
                param_high <= r.param_high;
                param_low  <= r.param_low;
                in_valid   <= 1'b1;
                requests_shown++;
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    // monitor: predict on accepted requests, check accepted results
    always @(posedge clk)
    begin : monitor
        request_t    r;
        frame_beat_t want;
        if (rst_n)
        begin
            if (in_valid && !in_stall)
            begin
                r.command    = command;
                r.rx_byte    = rx_byte;
                r.cmd_code   = cmd_code;
                r.param_high = param_high;
                r.param_low  = param_low;
                predict_player_step(r);
                requests_taken++;
            end
            if (out_valid && !out_stall)
            begin
                if (due_beats.size() == 0)
                begin
                    report_mismatch("result with nothing expected", 16'(tx_byte), 16'h0000);
                end
                else
                begin
                    want = due_beats.pop_front();
                    results_checked++;
                    check_field("is_tx_byte", 16'(is_tx_byte), 16'(want.is_tx));
                    check_field("tx_byte", 16'(tx_byte), 16'(want.tx));
                    check_field("last_of_run", 16'(last_of_run), 16'(want.last));
                    check_field("rx_outcome", 16'(rx_outcome), 16'(want.outcome));
                    check_field("card_inserted", 16'(card_inserted), 16'(want.st.card));
                    check_field("track_value", track_value, want.st.track);
                    check_field("player_status", 16'(player_status), 16'(want.st.status));
                    check_field("volume_level", 16'(volume_level), 16'(want.st.volume));
                    check_field("response_code", 16'(response_code),
                                16'(want.st.resp_code));
                    check_field("response_data", response_data, want.st.resp_data);
                    check_field("sent_code", 16'(sent_code), 16'(want.st.sent_code));
                    check_field("sent_data", sent_data, want.st.sent_data);
                end
            end
        end
    end

    // watchdog on cycles with no handshake at all
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
        begin
            stuck_cycles <= 0;
        end
        else
        begin
            stuck_cycles <= stuck_cycles + 1;
        end
        if (stuck_cycles >= STUCK_LIMIT)
        begin
            $display("no handshake for %0d cycles", STUCK_LIMIT);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // phases: directed then random, with the idling pattern changed per phase
    initial
    begin
        send_idle_pct = 31;
        recv_idle_pct = 55;

        // volume clamp above, at and just past the limit, and field extremes
        push_send(CMD_SET_VOLUME, 8'h00, 8'hFF);
        push_send(CMD_SET_VOLUME, 8'hFF, VOLUME_MAX);
        push_send(CMD_SET_VOLUME, 8'h12, VOLUME_MAX + 8'd1);
        push_send(8'hFF, 8'hFF, 8'hFF);
        push_send(8'h00, 8'h00, 8'h00);
        // end mark while waiting for start is just stored
        push_rx(END_MARK);
        // short frame decoded from stale buffer bytes
        push_rx(START_MARK);
        push_rx(RSP_VOLUME);
        push_rx(END_MARK);
        // track load, then zero status clears the track
        push_frame(RSP_TRACK, FEEDBACK, 8'hFF, 8'hFF);
        push_frame(RSP_STATUS, 8'h00, 8'h00, 8'h00);
        add_random_requests(BATCH_ITEMS);

        repeat (7) @(negedge clk);
        rst_n <= 1'b1;

        while (request_q.size() != 0 || in_valid) @(posedge clk);
        send_idle_pct = 55;
        recv_idle_pct = 31;
        add_random_requests(BATCH_ITEMS);

        while (request_q.size() != 0 || in_valid) @(posedge clk);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        add_random_requests(BATCH_ITEMS);

        while (request_q.size() != 0 || in_valid) @(posedge clk);
        while (due_beats.size() != 0) @(negedge clk);
        repeat (TAIL_CYCLES) @(negedge clk);

        while (due_beats.size() != 0)
        begin
            void'(due_beats.pop_front());
            report_mismatch("expected result never came", 16'h0000, 16'h0001);
        end

        $display("covered %0d requests: %0d sends, %0d received bytes, %0d results checked",
                 requests_taken, sends_done, bytes_taken, results_checked);
        $display("closed %0d response frames, %0d with unrecognized codes, %0d mismatches",
                 frames_closed, frames_unknown, mismatches);
        if (mismatches == 0)
        begin
            $display("SCOREBOARD CLEAN");
        end
        else
        begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

>>> serial_command_frame_engine_core.f
src/scfe_pkg.sv
src/scfe_rx.sv
src/scfe_state.sv
src/scfe_tx.sv
src/serial_command_frame_engine_core.sv
tb/sv/serial_command_frame_engine_core_test.sv
